/* hdl/qvr_pkg.sv */
`default_nettype none

package qvr_pkg;

    // Bit positions of the result sideband.
    localparam int TUSER_ZERO_NORM = 0;
    localparam int TUSER_SATURATED = 1;
    localparam int TUSER_W         = 2;

    // Status of one divider lane for the beat in its output register.
    typedef struct packed {
        logic div_zero;
        logic sat;
    } t_lane_flags;

endpackage

`default_nettype wire

/* hdl/qvr_div_lane.sv */
`default_nettype none

module qvr_div_lane
    import qvr_pkg::*;
#(
    parameter int W  = 16,
    parameter int NW = 52,
    parameter int DW = 33
) (
    input  wire                 i_clk,
    input  wire  [W+3:0]        i_en,
    input  wire  [NW-1:0]       i_num,
    input  wire  [DW-1:0]       i_den,
    output logic signed [W-1:0] o_rot,
    output t_lane_flags         o_flags
);

    localparam int BITS = W + 1;
    localparam int CW   = NW + W + 2;
    localparam int QW   = W + 2;
    localparam int LAST = BITS + 1;

    localparam logic [QW-1:0] QMAX_POS = (QW'(1) << (W - 1)) - QW'(1);
    localparam logic [QW-1:0] QMAX_NEG = QW'(1) << (W - 1);
    localparam logic signed [W-1:0] ROT_MAX = W'((QW'(1) << (W - 1)) - QW'(1));
    localparam logic signed [W-1:0] ROT_MIN = W'(QW'(1) << (W - 1));

    logic [NW-1:0]   r_mag0;
    logic            r_neg0;
    logic [DW-1:0]   r_d0;

    logic [NW-1:0]   r_rem [1:LAST];
    logic [BITS-1:0] r_q   [1:LAST];
    logic            r_neg [1:LAST];
    logic            r_ovf [1:LAST];
    logic            r_dz  [1:LAST];
    logic [DW-1:0]   r_d   [1:LAST];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg0 <= i_num[NW-1];
            r_mag0 <= i_num[NW-1] ? (NW'(0) - i_num) : i_num;
            r_d0   <= i_den;
        end
    end

    // The quotient is developed over BITS bits only; anything larger saturates anyway.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[1] <= r_mag0;
            r_q[1]   <= '0;
            r_neg[1] <= r_neg0;
            r_ovf[1] <= CW'(r_mag0) >= (CW'(r_d0) << BITS);
            r_dz[1]  <= (r_d0 == '0);
            r_d[1]   <= r_d0;
        end
    end

    for (genvar j = 2; j <= LAST; j++) begin : g_step
        localparam int K = LAST - j;
        logic [CW-1:0]   n_sub;
        logic            n_ge;
        logic [BITS-1:0] n_q;

        always_comb begin
            n_sub  = CW'(r_d[j-1]) << K;
            n_ge   = CW'(r_rem[j-1]) >= n_sub;
            n_q    = r_q[j-1];
            n_q[K] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= n_ge ? (r_rem[j-1] - NW'(n_sub)) : r_rem[j-1];
                r_q[j]   <= n_q;
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_dz[j]  <= r_dz[j-1];
                r_d[j]   <= r_d[j-1];
            end
        end
    end

    logic              n_up;
    logic [QW-1:0]     n_qr;
    logic signed [W-1:0] n_rot;
    logic              n_sat;

    // Round half away from zero on the magnitude, then clip to the signed range; a zero divisor gives zero.
    always_comb begin
        n_up  = ({1'b0, r_rem[LAST]} << 1) >= (NW + 1)'(r_d[LAST]);
        n_qr  = QW'(r_q[LAST]) + QW'(n_up);
        n_sat = 1'b0;
        n_rot = '0;
        if (r_dz[LAST]) begin
            n_rot = '0;
        end else if (r_ovf[LAST]) begin
            n_sat = 1'b1;
            n_rot = r_neg[LAST] ? ROT_MIN : ROT_MAX;
        end else if (!r_neg[LAST] && (n_qr > QMAX_POS)) begin
            n_sat = 1'b1;
            n_rot = ROT_MAX;
        end else if (r_neg[LAST] && (n_qr > QMAX_NEG)) begin
            n_sat = 1'b1;
            n_rot = ROT_MIN;
        end else begin
            n_rot = r_neg[LAST] ? W'(QW'(0) - n_qr) : W'(n_qr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[W+3]) begin
            o_rot            <= n_rot;
            o_flags.sat      <= n_sat;
            o_flags.div_zero <= r_dz[LAST];
        end
    end

endmodule

`default_nettype wire

/* hdl/quaternion_vector_rotate.sv */
`default_nettype none
// Rotates a vector by a quaternion, q * p * conj(q) / |q|^2, in a fully pipelined datapath.
// Throughput: one beat per cycle while the output is not stalled; the depth is set by the
// restoring divider, one bit a stage.
// Bubbles collapse, so a stalled output only holds input once every stage is full.
// Reset clears the stage valid bits only; no result is in flight after reset.

module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int COMP_WIDTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // quat_real, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z
    input  wire  [((7*COMP_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [((3*COMP_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // zero_norm, saturated
    output logic [TUSER_W-1:0]      o_m_axis_tuser
);

    localparam int W      = COMP_WIDTH;
    localparam int OUT_DW = ((3 * W + 7) / 8) * 8;
    localparam int PW     = 2 * W;
    localparam int SW     = 2 * W + 2;
    localparam int DW     = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int NW     = (3 * W + 4 > 64) ? 64 : 3 * W + 4;
    localparam int FRONT  = 5;
    localparam int L      = FRONT + W + 4;

    logic [L:0]   en;
    logic [L-1:0] r_v;
    logic [L-1:0] r_zf;
    logic [L-1:0] n_v;
    logic [L-1:0] n_zf;
    logic         in_zero;

    assign en[L] = i_m_axis_tready;
    for (genvar g = 0; g < L; g++) begin : g_en
        assign en[g] = !r_v[g] || en[g+1];
    end

    assign in_zero = (i_s_axis_tdata[4*W-1:0] == '0);
    assign n_v     = {r_v[L-2:0], i_s_axis_tvalid};
    assign n_zf    = {r_zf[L-2:0], in_zero};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < L; i++) begin
                if (en[i]) begin
                    r_v[i] <= n_v[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < L; i++) begin
            if (en[i]) begin
                r_zf[i] <= n_zf[i];
            end
        end
    end

    // Stage 0: input register.
    logic signed [W-1:0] r0_s, r0_a, r0_b, r0_c, r0_x, r0_y, r0_z;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_s <= i_s_axis_tdata[0*W +: W];
            r0_a <= i_s_axis_tdata[1*W +: W];
            r0_b <= i_s_axis_tdata[2*W +: W];
            r0_c <= i_s_axis_tdata[3*W +: W];
            r0_x <= i_s_axis_tdata[4*W +: W];
            r0_y <= i_s_axis_tdata[5*W +: W];
            r0_z <= i_s_axis_tdata[6*W +: W];
        end
    end

    // Stage 1: the quaternion squares and the quaternion-vector products.
    logic signed [PW-1:0] r1_ss, r1_aa, r1_bb, r1_cc, r1_ax, r1_by, r1_cz;
    logic signed [PW-1:0] r1_bz, r1_cy, r1_cx, r1_az, r1_ay, r1_bx;
    logic signed [W-1:0]  r1_s, r1_a, r1_b, r1_c, r1_x, r1_y, r1_z;
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_ss <= r0_s * r0_s;
            r1_aa <= r0_a * r0_a;
            r1_bb <= r0_b * r0_b;
            r1_cc <= r0_c * r0_c;
            r1_ax <= r0_a * r0_x;
            r1_by <= r0_b * r0_y;
            r1_cz <= r0_c * r0_z;
            r1_bz <= r0_b * r0_z;
            r1_cy <= r0_c * r0_y;
            r1_cx <= r0_c * r0_x;
            r1_az <= r0_a * r0_z;
            r1_ay <= r0_a * r0_y;
            r1_bx <= r0_b * r0_x;
            r1_s  <= r0_s;
            r1_a  <= r0_a;
            r1_b  <= r0_b;
            r1_c  <= r0_c;
            r1_x  <= r0_x;
            r1_y  <= r0_y;
            r1_z  <= r0_z;
        end
    end

    // Stage 2: norm squared, scalar term, twice the dot product and the cross product.
    logic [DW-1:0]        r2_d;
    logic signed [SW-1:0] r2_diff, r2_dot2, r2_ux, r2_uy, r2_uz;
    logic signed [W-1:0]  r2_s, r2_a, r2_b, r2_c, r2_x, r2_y, r2_z;
    logic signed [SW-1:0] n2_d;
    assign n2_d = SW'(r1_ss) + SW'(r1_aa) + SW'(r1_bb) + SW'(r1_cc);
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_d    <= DW'(n2_d);
            r2_diff <= SW'(r1_ss) - SW'(r1_aa) - SW'(r1_bb) - SW'(r1_cc);
            r2_dot2 <= (SW'(r1_ax) + SW'(r1_by) + SW'(r1_cz)) <<< 1;
            r2_ux   <= SW'(r1_bz) - SW'(r1_cy);
            r2_uy   <= SW'(r1_cx) - SW'(r1_az);
            r2_uz   <= SW'(r1_ay) - SW'(r1_bx);
            r2_s    <= r1_s;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_c    <= r1_c;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
        end
    end

    // Stage 3: the three numerator terms per axis, kept modulo 2^NW.
    logic signed [NW-1:0] r3_t1x, r3_t2x, r3_t3x, r3_t1y, r3_t2y, r3_t3y;
    logic signed [NW-1:0] r3_t1z, r3_t2z, r3_t3z;
    logic [DW-1:0]        r3_d;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_t1x <= NW'(r2_diff) * NW'(r2_x);
            r3_t1y <= NW'(r2_diff) * NW'(r2_y);
            r3_t1z <= NW'(r2_diff) * NW'(r2_z);
            r3_t2x <= NW'(r2_dot2) * NW'(r2_a);
            r3_t2y <= NW'(r2_dot2) * NW'(r2_b);
            r3_t2z <= NW'(r2_dot2) * NW'(r2_c);
            r3_t3x <= NW'(r2_s) * NW'(r2_ux);
            r3_t3y <= NW'(r2_s) * NW'(r2_uy);
            r3_t3z <= NW'(r2_s) * NW'(r2_uz);
            r3_d   <= r2_d;
        end
    end

    // Stage 4: numerator sums.
    logic [NW-1:0] r4_nx, r4_ny, r4_nz;
    logic [DW-1:0] r4_d;
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_nx <= r3_t1x + r3_t2x + (r3_t3x <<< 1);
            r4_ny <= r3_t1y + r3_t2y + (r3_t3y <<< 1);
            r4_nz <= r3_t1z + r3_t2z + (r3_t3z <<< 1);
            r4_d  <= r3_d;
        end
    end

    logic signed [W-1:0] rot_x, rot_y, rot_z;
    t_lane_flags         fl_x, fl_y, fl_z;

    qvr_div_lane #(.W(W), .NW(NW), .DW(DW)) u_div_x (
        .i_clk   (i_clk),
        .i_en    (en[FRONT +: W+4]),
        .i_num   (r4_nx),
        .i_den   (r4_d),
        .o_rot   (rot_x),
        .o_flags (fl_x)
    );

    qvr_div_lane #(.W(W), .NW(NW), .DW(DW)) u_div_y (
        .i_clk   (i_clk),
        .i_en    (en[FRONT +: W+4]),
        .i_num   (r4_ny),
        .i_den   (r4_d),
        .o_rot   (rot_y),
        .o_flags (fl_y)
    );

    qvr_div_lane #(.W(W), .NW(NW), .DW(DW)) u_div_z (
        .i_clk   (i_clk),
        .i_en    (en[FRONT +: W+4]),
        .i_num   (r4_nz),
        .i_den   (r4_d),
        .o_rot   (rot_z),
        .o_flags (fl_z)
    );

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_v[L-1];
    assign o_m_axis_tdata  = OUT_DW'({rot_z, rot_y, rot_x});
    always_comb begin
        o_m_axis_tuser                  = '0;
        o_m_axis_tuser[TUSER_ZERO_NORM] = r_zf[L-1];
        o_m_axis_tuser[TUSER_SATURATED] = !r_zf[L-1] && (fl_x.sat || fl_y.sat || fl_z.sat);
    end

`ifndef SYNTHESIS
    localparam logic signed [W-1:0] A_MAX = W'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [W-1:0] A_MIN = W'(64'd1 << (W - 1));

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_zf[L-1]) |->
            (rot_x == '0 && rot_y == '0 && rot_z == '0 && fl_x.div_zero
             && !o_m_axis_tuser[TUSER_SATURATED]))
        else $error("zero quaternion beat with nonzero result");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[TUSER_SATURATED]) |->
            (rot_x == A_MAX || rot_x == A_MIN || rot_y == A_MAX || rot_y == A_MIN
             || rot_z == A_MAX || rot_z == A_MIN))
        else $error("saturated flag without a clipped component");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_v))
        else $error("input stalled while a pipeline stage is empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
